FILE: rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros for the ordered set rank query block.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/osrq_pkg.sv
// osrq_pkg: shared constants, codes, cell command type and helper function
// for the ordered set rank query block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package osrq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W        = 32;
    localparam int OP_W         = 3;
    localparam int RANK_W       = 11;
    localparam int STATUS_W     = 2;
    localparam int RED_GROUP    = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_SMALL  = 3'd3;
    localparam logic [OP_W-1:0] OP_LARGE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOEFFECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             cmp;
        logic             ins;
        logic             ers;
        logic [KEY_W-1:0] probe;
    } t_cell_cmd;

    // number of registered OR levels needed to reduce n entries
    function automatic int red_levels(input int n);
        int m;
        int l;
        m = n;
        l = 0;
        while (m > 1) begin
            m = (m + RED_GROUP - 1) / RED_GROUP;
            l = l + 1;
        end
        if (l < 1) begin
            l = 1;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/osrq_cell.sv
// osrq_cell: one slot of the sorted key row. Holds a key, compares it with the
// broadcast probe, and shifts with its neighbors. Depends on osrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module osrq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 11,
    parameter int AW  = 10
) (
    input  wire logic                        i_clk,
    input  wire osrq_pkg::t_cell_cmd         i_cmd,
    input  wire logic [CW-1:0]               i_count,
    input  wire logic [AW-1:0]               i_idx,
    input  wire logic [osrq_pkg::KEY_W-1:0]  i_left_key,
    input  wire logic                        i_left_lt,
    input  wire logic [osrq_pkg::KEY_W-1:0]  i_right_key,
    output logic [osrq_pkg::KEY_W-1:0]       o_key,
    output logic                             o_lt,
    output logic [osrq_pkg::KEY_W:0]         o_red
);

    logic [osrq_pkg::KEY_W-1:0] r_key;
    logic                       r_lt;
    logic [osrq_pkg::KEY_W:0]   r_red;
    logic                       occupied;
    logic                       is_eq;
    logic                       is_sel;

    assign occupied = CW'(IDX) < i_count;
    assign is_eq    = occupied && (r_key == i_cmd.probe);
    assign is_sel   = (AW'(IDX) == i_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_lt  <= occupied && ($signed(r_key) < $signed(i_cmd.probe));
            r_red <= {is_eq, (is_sel ? r_key : {osrq_pkg::KEY_W{1'b0}})};
        end
        if (i_cmd.ins && !r_lt) begin
            r_key <= i_left_lt ? i_cmd.probe : i_left_key;
        end else if (i_cmd.ers && !r_lt) begin
            r_key <= i_right_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_red = r_red;

endmodule

`default_nettype wire

FILE: rtl/core/osrq_reduce.sv
// osrq_reduce: registered OR tree over the cell row, RED_GROUP inputs per node.
// Depends on osrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module osrq_reduce #(
    parameter int N = 1024,
    parameter int W = 33
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_data [N],
    output logic [W-1:0]      o_data
);

    localparam int LEVELS = osrq_pkg::red_levels(N);
    localparam int G      = osrq_pkg::RED_GROUP;
    localparam int NODES  = (N + G - 1) / G;

    logic [W-1:0] r_lvl [LEVELS][NODES];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NODES; j++) begin
            logic [W-1:0] acc;
            acc = '0;
            for (int k = 0; k < G; k++) begin
                if (j * G + k < N) begin
                    acc = acc | i_data[j * G + k];
                end
            end
            r_lvl[0][j] <= acc;
        end
    end

    for (genvar l = 1; l < LEVELS; l++) begin : g_lvl
        always_ff @(posedge i_clk) begin
            for (int j = 0; j < NODES; j++) begin
                logic [W-1:0] acc;
                acc = '0;
                for (int k = 0; k < G; k++) begin
                    if (j * G + k < NODES) begin
                        acc = acc | r_lvl[l-1][j * G + k];
                    end
                end
                r_lvl[l][j] <= acc;
            end
        end
    end

    assign o_data = r_lvl[LEVELS-1][0];

endmodule

`default_nettype wire

FILE: rtl/core/ordered_set_rank_query.sv
// ordered_set_rank_query: top level, control sequencer around the cell row
// and the OR tree. Depends on osrq_pkg, osrq_cell, osrq_reduce, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Keeps a sorted set of distinct signed keys in a row of CAPACITY cells, one
// key per cell. A command is taken when start is high and busy is low. Each
// command gives exactly one result, shown for one cycle with o_valid high; the
// receiver cannot stall, so it must take the result in that cycle. One pass
// is a compare in every cell, then the L registered levels of the OR tree
// (L = ceil(log32(CAPACITY)), 2 at 1024 entries), then a decide-and-shift
// step, and the result is shown in the cycle after that step. Insert, erase,
// rank queries, unused codes and an update whose old key is absent take one
// pass. An update whose new key is already present takes two passes. An
// update that succeeds takes four passes (old key check, new key check,
// erase, insert).
module ordered_set_rank_query #(
    parameter int CAPACITY = osrq_pkg::CAPACITY_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [osrq_pkg::OP_W-1:0]             i_operation,
    input  wire logic signed [osrq_pkg::KEY_W-1:0]     i_key,
    input  wire logic signed [osrq_pkg::KEY_W-1:0]     i_new_key,
    input  wire logic [osrq_pkg::RANK_W-1:0]           i_rank,
    output logic                                       o_valid,
    output logic [osrq_pkg::STATUS_W-1:0]              o_status,
    output logic signed [osrq_pkg::KEY_W-1:0]          o_value
);

    localparam int KW     = osrq_pkg::KEY_W;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int AW     = $clog2(CAPACITY);
    localparam int MW     = (CW > osrq_pkg::RANK_W) ? CW : osrq_pkg::RANK_W;
    localparam int LEVELS = osrq_pkg::red_levels(CAPACITY);
    localparam int WW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_RED  = 4'b0100,
        S_CHK  = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        PH_OLD = 4'b0001,
        PH_NEW = 4'b0010,
        PH_ERS = 4'b0100,
        PH_INS = 4'b1000
    } t_phase;

    t_state                        r_state, n_state;
    t_phase                        r_phase, n_phase;
    logic [CW-1:0]                 r_count, n_count;
    logic [WW-1:0]                 r_wait, n_wait;
    logic [osrq_pkg::OP_W-1:0]     r_op, n_op;
    logic [KW-1:0]                 r_probe, n_probe;
    logic [KW-1:0]                 r_okey, n_okey;
    logic [KW-1:0]                 r_nkey, n_nkey;
    logic [AW-1:0]                 r_idx, n_idx;
    logic                          r_valid, n_valid;
    logic [osrq_pkg::STATUS_W-1:0] r_status, n_status;
    logic [KW-1:0]                 r_value, n_value;

    osrq_pkg::t_cell_cmd           cmd;
    logic [KW-1:0]                 cell_key [CAPACITY];
    logic                          cell_lt  [CAPACITY];
    logic [KW:0]                   cell_red [CAPACITY];
    logic [KW:0]                   red_out;
    logic                          found;

    logic [MW-1:0]                 rank_ext;
    logic [MW-1:0]                 count_ext;
    logic [MW-1:0]                 rank_clamp;
    logic [AW-1:0]                 idx_small;
    logic [AW-1:0]                 idx_large;

    // cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KW-1:0] left_key;
        logic          left_lt;
        logic [KW-1:0] right_key;
        if (i == 0) begin : g_first
            assign left_key = '0;
            assign left_lt  = 1'b1;
        end else begin : g_mid
            assign left_key = cell_key[i-1];
            assign left_lt  = cell_lt[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_key = cell_key[i];
        end else begin : g_inner
            assign right_key = cell_key[i+1];
        end
        osrq_cell #(
            .IDX (i),
            .CW  (CW),
            .AW  (AW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_count     (r_count),
            .i_idx       (r_idx),
            .i_left_key  (left_key),
            .i_left_lt   (left_lt),
            .i_right_key (right_key),
            .o_key       (cell_key[i]),
            .o_lt        (cell_lt[i]),
            .o_red       (cell_red[i])
        );
    end

    osrq_reduce #(
        .N (CAPACITY),
        .W (KW + 1)
    ) u_reduce (
        .i_clk  (i_clk),
        .i_data (cell_red),
        .o_data (red_out)
    );

    assign found = red_out[KW];

    // rank clamp: zero reads as one, above count reads as count
    always_comb begin
        rank_ext  = MW'(i_rank);
        count_ext = MW'(r_count);
        if (rank_ext == '0) begin
            rank_ext = MW'(1);
        end
        rank_clamp = (rank_ext > count_ext) ? count_ext : rank_ext;
        idx_small  = AW'(rank_clamp - MW'(1));
        idx_large  = AW'(count_ext - rank_clamp);
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_count   = r_count;
        n_wait    = r_wait;
        n_op      = r_op;
        n_probe   = r_probe;
        n_okey    = r_okey;
        n_nkey    = r_nkey;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_value   = r_value;
        cmd       = '0;
        cmd.probe = r_probe;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_probe = i_key;
                    n_okey  = i_key;
                    n_nkey  = i_new_key;
                    n_phase = PH_OLD;
                    n_idx   = (i_operation == osrq_pkg::OP_LARGE) ? idx_large : idx_small;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                cmd.cmp = 1'b1;
                n_wait  = '0;
                n_state = S_RED;
            end
            S_RED: begin
                if (r_wait == WW'(LEVELS - 1)) begin
                    n_state = S_CHK;
                end else begin
                    n_wait = r_wait + WW'(1);
                end
            end
            S_CHK: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = osrq_pkg::ST_NOEFFECT;
                n_value  = '0;
                case (r_op)
                    osrq_pkg::OP_INSERT: begin
                        if (found) begin
                            n_status = osrq_pkg::ST_NOEFFECT;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = osrq_pkg::ST_FULL;
                        end else begin
                            cmd.ins  = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_status = osrq_pkg::ST_DONE;
                        end
                    end
                    osrq_pkg::OP_ERASE: begin
                        if (found) begin
                            cmd.ers  = 1'b1;
                            n_count  = r_count - CW'(1);
                            n_status = osrq_pkg::ST_DONE;
                        end
                    end
                    osrq_pkg::OP_UPDATE: begin
                        case (r_phase)
                            PH_OLD: begin
                                if (found) begin
                                    n_valid = 1'b0;
                                    n_probe = r_nkey;
                                    n_phase = PH_NEW;
                                    n_state = S_CMP;
                                end
                            end
                            PH_NEW: begin
                                if (!found) begin
                                    n_valid = 1'b0;
                                    n_probe = r_okey;
                                    n_phase = PH_ERS;
                                    n_state = S_CMP;
                                end
                            end
                            PH_ERS: begin
                                cmd.ers = 1'b1;
                                n_count = r_count - CW'(1);
                                n_valid = 1'b0;
                                n_probe = r_nkey;
                                n_phase = PH_INS;
                                n_state = S_CMP;
                            end
                            PH_INS: begin
                                cmd.ins  = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_status = osrq_pkg::ST_DONE;
                            end
                            default: begin
                                n_phase = PH_OLD;
                            end
                        endcase
                    end
                    osrq_pkg::OP_SMALL, osrq_pkg::OP_LARGE: begin
                        if (r_count == '0) begin
                            n_status = osrq_pkg::ST_EMPTY;
                        end else begin
                            n_status = osrq_pkg::ST_DONE;
                            n_value  = red_out[KW-1:0];
                        end
                    end
                    default: begin
                        n_status = osrq_pkg::ST_NOEFFECT;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_OLD;
            r_count <= '0;
            r_wait  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_wait  <= n_wait;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_probe  <= n_probe;
        r_okey   <= n_okey;
        r_nkey   <= n_nkey;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_value  <= n_value;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_value  = r_value;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && r_state == S_CMP)
    `ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_valid && o_status == osrq_pkg::ST_EMPTY, o_value == '0)

endmodule

`default_nettype wire

FILE: tb/ordered_set_rank_query_tb.sv
// ordered_set_rank_query_tb: self-checking bench for the ordered set rank query block.
// Runs directed and random insert/erase/update/rank transfers against a sorted-set predictor.
// Depends on osrq_pkg and the ordered_set_rank_query RTL.
`timescale 1ns / 1ps

module ordered_set_rank_query_tb;

    import osrq_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;

    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic [RANK_W-1:0]       RANK_TOP = '1;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] value;
    } t_outcome;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [OP_W-1:0]            i_operation = '0;
    logic signed [KEY_W-1:0]    i_key = '0;
    logic signed [KEY_W-1:0]    i_new_key = '0;
    logic [RANK_W-1:0]          i_rank = '0;
    logic                       o_valid;
    logic [STATUS_W-1:0]        o_status;
    logic signed [KEY_W-1:0]    o_value;

    // predicted set contents, ascending signed order in [0, set_count)
    logic signed [KEY_W-1:0]    set_keys [CAPACITY];
    int unsigned                set_count = 0;

    t_outcome                   outcome_q [$];
    t_outcome                   outcome_head;
    int unsigned                mismatch_count = 0;
    bit                         idle_allowed = 1'b1;
    int unsigned                idle_pct = 20;

    ordered_set_rank_query #(
        .CAPACITY    (CAPACITY)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_new_key   (i_new_key),
        .i_rank      (i_rank),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value     (o_value)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #12_000_000;
        $display("[ordered_set_rank_query] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned first_not_below(input logic signed [KEY_W-1:0] k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = set_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (set_keys[mid] < k) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic bit set_holds(input logic signed [KEY_W-1:0] k);
        int unsigned pos;
        pos = first_not_below(k);
        return (pos < set_count) && (set_keys[pos] == k);
    endfunction

    function automatic logic [STATUS_W-1:0] set_insert(input logic signed [KEY_W-1:0] k);
        int unsigned pos;
        pos = first_not_below(k);
        if ((pos < set_count) && (set_keys[pos] == k)) begin
            return ST_NOEFFECT;
        end
        if (set_count >= CAPACITY) begin
            return ST_FULL;
        end
        for (int unsigned i = set_count; i > pos; i--) begin
            set_keys[i] = set_keys[i-1];
        end
        set_keys[pos] = k;
        set_count++;
        return ST_DONE;
    endfunction

    function automatic logic [STATUS_W-1:0] set_erase(input logic signed [KEY_W-1:0] k);
        int unsigned pos;
        pos = first_not_below(k);
        if (!((pos < set_count) && (set_keys[pos] == k))) begin
            return ST_NOEFFECT;
        end
        for (int unsigned i = pos; i + 1 < set_count; i++) begin
            set_keys[i] = set_keys[i+1];
        end
        set_count--;
        return ST_DONE;
    endfunction

    function automatic t_outcome apply_set_op(
        input logic [OP_W-1:0]          op,
        input logic signed [KEY_W-1:0]  k,
        input logic signed [KEY_W-1:0]  nk,
        input logic [RANK_W-1:0]        r
    );
        t_outcome    res;
        int unsigned idx;
        res.status = ST_NOEFFECT;
        res.value  = '0;
        case (op)
            OP_INSERT: begin
                res.status = set_insert(k);
            end
            OP_ERASE: begin
                res.status = set_erase(k);
            end
            OP_UPDATE: begin
                if (set_holds(k) && !set_holds(nk)) begin
                    void'(set_erase(k));
                    void'(set_insert(nk));
                    res.status = ST_DONE;
                end
            end
            OP_SMALL, OP_LARGE: begin
                if (set_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    idx = (r == '0) ? 1 : int'(r);
                    if (idx > set_count) begin
                        idx = set_count;
                    end
                    res.value  = (op == OP_SMALL) ? set_keys[idx-1] : set_keys[set_count-idx];
                    res.status = ST_DONE;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- checker

    task automatic note_failure(input string msg);
        if (mismatch_count < 10) begin
            $display("%s", msg);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (outcome_q.size() == 0) begin
                note_failure($sformatf("unexpected result: status %0d value %0d",
                                       o_status, o_value));
            end else begin
                outcome_head = outcome_q.pop_front();
                if (o_status !== outcome_head.status || o_value !== outcome_head.value) begin
                    note_failure($sformatf(
                        "mismatch: exp status %0d value %0d, got status %0d value %0d",
                        outcome_head.status, outcome_head.value, o_status, o_value));
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic idle_gap();
        if (idle_allowed && $urandom_range(0, 49) == 0) begin
            idle_pct = $urandom_range(0, 2) * 20;
        end
        if (idle_allowed && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_item(
        input logic [OP_W-1:0]          op,
        input logic signed [KEY_W-1:0]  k,
        input logic signed [KEY_W-1:0]  nk,
        input logic [RANK_W-1:0]        r
    );
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= k;
        i_new_key   <= nk;
        i_rank      <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        outcome_q.push_back(apply_set_op(op, k, nk, r));
        idle_gap();
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned             sel;
        logic signed [KEY_W-1:0] k;
        sel = $urandom_range(0, 9);
        if (sel < 4 && set_count > 0) begin
            k = set_keys[$urandom_range(0, set_count - 1)];
        end else if (sel < 7) begin
            k = $urandom_range(0, 40);
            k = k - 20;
        end else if (sel == 7) begin
            case ($urandom_range(0, 3))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = KEY_MIN + 1;
                default: k = KEY_MAX - 1;
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    function automatic logic [RANK_W-1:0] pick_rank();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return RANK_W'($urandom_range(0, set_count + 1));
        end else if (sel < 8) begin
            return RANK_W'($urandom_range(0, 2047));
        end else if (sel == 8) begin
            return '0;
        end
        return RANK_TOP;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return OP_INSERT;
        if (sel < 50) return OP_ERASE;
        if (sel < 65) return OP_UPDATE;
        if (sel < 80) return OP_SMALL;
        if (sel < 95) return OP_LARGE;
        return OP_RSVD_A + OP_W'($urandom_range(0, 2));
    endfunction

    task automatic send_random_item();
        send_item(pick_op(), pick_key(), pick_key(), pick_rank());
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_empty_set();
        send_item(OP_SMALL, 32'sd0, 32'sd0, 11'd1);
        send_item(OP_LARGE, 32'sd0, 32'sd0, RANK_TOP);
        send_item(OP_ERASE, 32'sd0, 32'sd0, 11'd1);
        send_item(OP_UPDATE, 32'sd0, 32'sd1, 11'd1);
    endtask

    task automatic test_insert_erase();
        send_item(OP_INSERT, KEY_MIN, 32'sd0, 11'd0);
        send_item(OP_INSERT, KEY_MAX, 32'sd0, 11'd0);
        send_item(OP_INSERT, 32'sd0, 32'sd0, 11'd0);
        send_item(OP_INSERT, -32'sd1, 32'sd0, 11'd0);
        send_item(OP_INSERT, KEY_MAX, 32'sd0, 11'd0);
        send_item(OP_ERASE, 32'sd5, 32'sd0, 11'd0);
        send_item(OP_ERASE, -32'sd1, 32'sd0, 11'd0);
        send_item(OP_INSERT, -32'sd1, 32'sd0, 11'd0);
    endtask

    task automatic test_update_rules();
        send_item(OP_UPDATE, 32'sd0, 32'sd0, 11'd0);
        send_item(OP_UPDATE, 32'sd7, 32'sd8, 11'd0);
        send_item(OP_UPDATE, 32'sd0, KEY_MAX, 11'd0);
        send_item(OP_UPDATE, 32'sd0, KEY_MIN + 1, 11'd0);
    endtask

    task automatic test_rank_clamp();
        send_item(OP_SMALL, 32'sd0, 32'sd0, 11'd0);
        send_item(OP_SMALL, 32'sd0, 32'sd0, RANK_TOP);
        send_item(OP_LARGE, 32'sd0, 32'sd0, 11'd1);
        send_item(OP_LARGE, 32'sd0, 32'sd0, 11'd3);
        send_item(OP_LARGE, 32'sd0, 32'sd0, 11'd1024);
    endtask

    task automatic test_unused_ops();
        send_item(OP_RSVD_A, -32'sd1, KEY_MAX, 11'd1);
        send_item(OP_RSVD_B, KEY_MIN, 32'sd3, RANK_TOP);
        send_item(OP_RSVD_C, 32'sd0, -32'sd1, 11'd2);
    endtask

    task automatic test_random_mix(input int unsigned n);
        repeat (n) send_random_item();
    endtask

    // grow the set to capacity, then hit dropped inserts and full-table updates
    task automatic test_fill_to_capacity();
        int unsigned             guard;
        int unsigned             sel;
        logic signed [KEY_W-1:0] k;
        guard = 0;
        while (set_count < CAPACITY && guard < 2000) begin
            sel = $urandom_range(0, 99);
            if (sel < 88) begin
                send_item(OP_INSERT, $urandom, $urandom, pick_rank());
            end else if (sel < 92) begin
                send_item(OP_SMALL, $urandom, $urandom, pick_rank());
            end else if (sel < 96) begin
                send_item(OP_LARGE, $urandom, $urandom, pick_rank());
            end else begin
                send_item(OP_UPDATE, pick_key(), $urandom, pick_rank());
            end
            guard++;
        end
        repeat (8) send_item(OP_INSERT, $urandom, $urandom, pick_rank());
        send_item(OP_INSERT, set_keys[$urandom_range(0, set_count - 1)], 32'sd0, 11'd0);
        send_item(OP_SMALL, 32'sd0, 32'sd0, 11'd1024);
        send_item(OP_SMALL, 32'sd0, 32'sd0, RANK_TOP);
        send_item(OP_LARGE, 32'sd0, 32'sd0, 11'd1024);
        send_item(OP_LARGE, 32'sd0, 32'sd0, 11'd0);
        send_item(OP_UPDATE, set_keys[$urandom_range(0, set_count - 1)], $urandom, 11'd0);
        k = set_keys[$urandom_range(0, set_count - 1)];
        send_item(OP_ERASE, k, 32'sd0, 11'd0);
        send_item(OP_INSERT, $urandom, 32'sd0, 11'd0);
        send_item(OP_INSERT, k, 32'sd0, 11'd0);
        repeat (40) send_random_item();
    endtask

    task automatic test_back_to_back(input int unsigned n);
        idle_allowed = 1'b0;
        idle_pct     = 0;
        repeat (n) send_random_item();
    endtask

    initial begin
        int unsigned drain_cycles;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_set();
        test_insert_erase();
        test_update_rules();
        test_rank_clamp();
        test_unused_ops();
        test_random_mix(600);
        test_fill_to_capacity();
        test_back_to_back(250);

        start <= 1'b0;
        drain_cycles = 0;
        while (outcome_q.size() != 0 && drain_cycles < 2000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (24) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            note_failure($sformatf("missing results: %0d", outcome_q.size()));
        end

        if (mismatch_count == 0) begin
            $display("[ordered_set_rank_query] OK");
        end else begin
            $display("[ordered_set_rank_query] ERROR");
        end
        $finish;
    end

endmodule
